// ===== sv/toy_register_machine_execute_defines.svh =====
// ----------------------------------------------------------------------------
// Toy register machine execute - assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef TOY_REGISTER_MACHINE_EXECUTE_DEFINES_SVH
`define TOY_REGISTER_MACHINE_EXECUTE_DEFINES_SVH

// same-cycle implication, idle during reset
`define TRE_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("port check failed");

// next-cycle implication, idle during reset
`define TRE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("port check failed");

// next-cycle implication, live during reset
`define TRE_ASSERT_RST(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("reset check failed");

`endif

// ===== sv/tre_pkg.sv =====
// ----------------------------------------------------------------------------
// Toy register machine execute - package
// Instruction and result types, operation codes and port widths.
// ----------------------------------------------------------------------------
package tre_pkg;

    typedef enum logic [2:0] {
        FUNC_MOV = 3'd0,
        FUNC_ADD = 3'd1,
        FUNC_SUB = 3'd2,
        FUNC_JMP = 3'd3,
        FUNC_JPZ = 3'd4,
        FUNC_JPN = 3'd5,
        FUNC_PRN = 3'd6,
        FUNC_HLT = 3'd7
    } tre_func_t;

    typedef enum logic {
        FK_REG = 1'b0,
        FK_MEM = 1'b1
    } tre_fkind_t;

    typedef enum logic [1:0] {
        SK_REG   = 2'd0,
        SK_MEM   = 2'd1,
        SK_CONST = 2'd2,
        SK_NONE  = 2'd3
    } tre_skind_t;

    typedef struct packed {
        tre_func_t          func;
        tre_fkind_t         first_kind;
        logic [1:0]         second_kind;
        logic [2:0]         first_reg;
        logic [2:0]         second_reg;
        logic [5:0]         mem_addr;
        logic signed [31:0] immediate;
        logic [15:0]        target_line;
    } tre_instr_t;

    typedef struct packed {
        logic [15:0]        next_pc;
        logic               print_valid;
        logic signed [31:0] print_value;
        logic               halted;
    } tre_result_t;

    localparam logic [15:0] PC_RESET   = 16'd1;
    localparam int          OUTQ_DEPTH = 3;
    localparam int          S_TDATA_W  = 64;
    localparam int          S_TUSER_W  = 6;
    localparam int          M_TDATA_W  = 56;
    localparam int          M_TUSER_W  = 1;

endpackage

// ===== sv/tre_ram.sv =====
// ----------------------------------------------------------------------------
// Toy register machine execute - generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module tre_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/tre_core.sv =====
// ----------------------------------------------------------------------------
// Toy register machine execute - core
// Register file and data memory in RAMs, one read-modify-write stage with
// forwarding of the write made at the read edge, PC and halt flag.
// ----------------------------------------------------------------------------
module tre_core #(
    parameter int MEM_DEPTH  = 64,
    parameter int REG_COUNT  = 5,
    parameter int DATA_WIDTH = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_accept,
    input  tre_pkg::tre_instr_t  in_instr,
    output logic                 s1_busy,
    output tre_pkg::tre_result_t res,
    output logic                 res_valid
);

    localparam int RW  = $clog2(REG_COUNT);
    localparam int MAW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    logic                   s1_valid_reg;
    tre_pkg::tre_instr_t    s1_reg;
    logic [15:0]            pc_reg;
    logic [15:0]            pc_next;
    logic                   halt_reg;
    logic                   halt_next;
    logic [REG_COUNT-1:0]   reg_vld_reg;
    logic [MEM_DEPTH-1:0]   mem_vld_reg;

    logic                   fwd_reg_en_reg;
    logic [RW-1:0]          fwd_reg_idx_reg;
    logic [DATA_WIDTH-1:0]  fwd_reg_data_reg;
    logic                   fwd_mem_en_reg;
    logic [MAW-1:0]         fwd_mem_addr_reg;
    logic [DATA_WIDTH-1:0]  fwd_mem_data_reg;

    logic [DATA_WIDTH-1:0]  r1_rdata;
    logic [DATA_WIDTH-1:0]  r2_rdata;
    logic [DATA_WIDTH-1:0]  mem_rdata;

    logic [RW-1:0]          r1_idx;
    logic [RW-1:0]          r2_idx;
    logic [MAW-1:0]         m_idx;
    logic                   r1_ok;
    logic                   r2_ok;
    logic                   m_ok;
    logic [DATA_WIDTH-1:0]  r1_val;
    logic [DATA_WIDTH-1:0]  r2_val;
    logic [DATA_WIDTH-1:0]  mem_val;
    logic [DATA_WIDTH-1:0]  imm_ext;
    logic [DATA_WIDTH-1:0]  src_val;

    logic                   reg_we;
    logic [RW-1:0]          reg_widx;
    logic [DATA_WIDTH-1:0]  reg_wdata;
    logic                   mem_we;
    logic [DATA_WIDTH-1:0]  mem_wdata;
    logic                   pvalid;
    logic [DATA_WIDTH-1:0]  pval;

    tre_ram #(.WIDTH(DATA_WIDTH), .DEPTH(REG_COUNT)) u_rf_a (
        .clk   (aclk),
        .we    (reg_we),
        .waddr (reg_widx),
        .wdata (reg_wdata),
        .raddr (RW'(in_instr.first_reg)),
        .rdata (r1_rdata)
    );

    tre_ram #(.WIDTH(DATA_WIDTH), .DEPTH(REG_COUNT)) u_rf_b (
        .clk   (aclk),
        .we    (reg_we),
        .waddr (reg_widx),
        .wdata (reg_wdata),
        .raddr (RW'(in_instr.second_reg)),
        .rdata (r2_rdata)
    );

    tre_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MEM_DEPTH)) u_dmem (
        .clk   (aclk),
        .we    (mem_we),
        .waddr (m_idx),
        .wdata (mem_wdata),
        .raddr (MAW'(in_instr.mem_addr)),
        .rdata (mem_rdata)
    );

    assign r1_idx  = RW'(s1_reg.first_reg);
    assign r2_idx  = RW'(s1_reg.second_reg);
    assign m_idx   = MAW'(s1_reg.mem_addr);
    assign r1_ok   = int'(s1_reg.first_reg) < REG_COUNT;
    assign r2_ok   = int'(s1_reg.second_reg) < REG_COUNT;
    assign m_ok    = int'(s1_reg.mem_addr) < MEM_DEPTH;
    assign imm_ext = DATA_WIDTH'(s1_reg.immediate);

    // take the write made at the read edge ahead of the RAM data
    always_comb begin
        if (!r1_ok) begin
            r1_val = '0;
        end else if (fwd_reg_en_reg && (fwd_reg_idx_reg == r1_idx)) begin
            r1_val = fwd_reg_data_reg;
        end else if (reg_vld_reg[r1_idx]) begin
            r1_val = r1_rdata;
        end else begin
            r1_val = '0;
        end
    end

    always_comb begin
        if (!r2_ok) begin
            r2_val = '0;
        end else if (fwd_reg_en_reg && (fwd_reg_idx_reg == r2_idx)) begin
            r2_val = fwd_reg_data_reg;
        end else if (reg_vld_reg[r2_idx]) begin
            r2_val = r2_rdata;
        end else begin
            r2_val = '0;
        end
    end

    always_comb begin
        if (!m_ok) begin
            mem_val = '0;
        end else if (fwd_mem_en_reg && (fwd_mem_addr_reg == m_idx)) begin
            mem_val = fwd_mem_data_reg;
        end else if (mem_vld_reg[m_idx]) begin
            mem_val = mem_rdata;
        end else begin
            mem_val = '0;
        end
    end

    always_comb begin
        case (s1_reg.second_kind)
            tre_pkg::SK_REG:   src_val = r2_val;
            tre_pkg::SK_MEM:   src_val = mem_val;
            tre_pkg::SK_CONST: src_val = imm_ext;
            default:           src_val = '0;
        endcase
    end

    always_comb begin
        reg_we    = 1'b0;
        reg_widx  = r1_idx;
        reg_wdata = '0;
        mem_we    = 1'b0;
        mem_wdata = '0;
        pvalid    = 1'b0;
        pval      = '0;
        halt_next = halt_reg;
        pc_next   = halt_reg ? pc_reg : pc_reg + 16'd1;
        if (s1_valid_reg && !halt_reg) begin
            case (s1_reg.func)
                tre_pkg::FUNC_MOV: begin
                    if (s1_reg.second_kind == tre_pkg::SK_CONST) begin
                        if (s1_reg.first_kind == tre_pkg::FK_REG) begin
                            reg_we    = r1_ok;
                            reg_wdata = imm_ext;
                        end else begin
                            mem_we    = m_ok;
                            mem_wdata = imm_ext;
                        end
                    end else if (s1_reg.second_kind == tre_pkg::SK_REG) begin
                        reg_widx = r2_idx;
                        reg_we   = r2_ok;
                        if (s1_reg.first_kind == tre_pkg::FK_REG) begin
                            reg_wdata = r1_val;
                        end else begin
                            reg_wdata = mem_val;
                        end
                    end else if (s1_reg.second_kind == tre_pkg::SK_MEM &&
                                 s1_reg.first_kind == tre_pkg::FK_REG) begin
                        mem_we    = m_ok;
                        mem_wdata = r1_val;
                    end
                end
                tre_pkg::FUNC_ADD: begin
                    reg_we    = r1_ok && (s1_reg.second_kind != tre_pkg::SK_NONE);
                    reg_wdata = r1_val + src_val;
                end
                tre_pkg::FUNC_SUB: begin
                    reg_we    = r1_ok && (s1_reg.second_kind != tre_pkg::SK_NONE);
                    reg_wdata = r1_val - src_val;
                end
                tre_pkg::FUNC_JMP: begin
                    pc_next = s1_reg.target_line;
                end
                tre_pkg::FUNC_JPZ: begin
                    if (r1_val == '0) begin
                        pc_next = s1_reg.target_line;
                    end
                end
                tre_pkg::FUNC_JPN: begin
                    if (r1_val == '0 || r1_val[DATA_WIDTH-1]) begin
                        pc_next = s1_reg.target_line;
                    end
                end
                tre_pkg::FUNC_PRN: begin
                    pvalid = 1'b1;
                    pval   = (s1_reg.first_kind == tre_pkg::FK_REG) ? r1_val : mem_val;
                end
                default: begin
                    halt_next = 1'b1;
                    pc_next   = pc_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg   <= 1'b0;
            pc_reg         <= tre_pkg::PC_RESET;
            halt_reg       <= 1'b0;
            reg_vld_reg    <= '0;
            mem_vld_reg    <= '0;
            fwd_reg_en_reg <= 1'b0;
            fwd_mem_en_reg <= 1'b0;
        end else begin
            s1_valid_reg   <= in_accept;
            fwd_reg_en_reg <= reg_we;
            fwd_mem_en_reg <= mem_we;
            if (s1_valid_reg) begin
                pc_reg   <= pc_next;
                halt_reg <= halt_next;
            end
            if (reg_we) begin
                reg_vld_reg[reg_widx] <= 1'b1;
            end
            if (mem_we) begin
                mem_vld_reg[m_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            s1_reg <= in_instr;
        end
        fwd_reg_idx_reg  <= reg_widx;
        fwd_reg_data_reg <= reg_wdata;
        fwd_mem_addr_reg <= m_idx;
        fwd_mem_data_reg <= mem_wdata;
    end

    assign s1_busy         = s1_valid_reg;
    assign res_valid       = s1_valid_reg;
    assign res.next_pc     = pc_next;
    assign res.print_valid = pvalid;
    assign res.print_value = 32'(pval);
    assign res.halted      = halt_next;

endmodule

// ===== sv/tre_outq.sv =====
// ----------------------------------------------------------------------------
// Toy register machine execute - result queue
// Small register queue between the core and the result channel.
// ----------------------------------------------------------------------------
module tre_outq (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  tre_pkg::tre_result_t push_res,
    input  logic                 pop_ready,
    output logic                 head_valid,
    output tre_pkg::tre_result_t head_res,
    output logic [1:0]           count
);

    localparam int DEPTH = tre_pkg::OUTQ_DEPTH;

    tre_pkg::tre_result_t slot_reg [DEPTH];
    logic [1:0]           wr_ptr_reg;
    logic [1:0]           rd_ptr_reg;
    logic [1:0]           cnt_reg;
    logic [1:0]           cnt_next;
    logic                 pop;

    function automatic logic [1:0] ptr_inc(input logic [1:0] p);
        logic [1:0] r;
        r = (p == 2'(DEPTH - 1)) ? 2'd0 : p + 2'd1;
        return r;
    endfunction

    assign head_valid = (cnt_reg != 2'd0);
    assign head_res   = slot_reg[rd_ptr_reg];
    assign pop        = head_valid && pop_ready;
    assign count      = cnt_reg;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            cnt_reg    <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_res;
        end
    end

endmodule

// ===== sv/toy_register_machine_execute.sv =====
// ----------------------------------------------------------------------------
// Toy register machine execute - top level
// Executes one decoded instruction per input transfer and returns one result.
// ----------------------------------------------------------------------------
// Input channel (s_): one decoded instruction per transfer; opcode and operand
// kinds in s_tuser, register indexes, address, constant and target in s_tdata.
// Result channel (m_): one transfer per instruction with the new PC, the halt
// flag and any printed value; m_tuser flags a printed value.
// The RAM read is registered at the transfer edge and the executed result
// enters the result queue at the next edge, which raises m_tvalid.
// Throughput: one instruction per cycle while s_tready stays high, set by the
// single read-modify-write stage around the registered RAM reads; a write made
// at the read edge is forwarded to the following instruction.
// Reset: PC goes to one, the halt flag clears and valid bits mark every
// register and memory word as zero at once; no clearing pass is needed.
// Stall: a three-entry result queue absorbs results while m_tready is low;
// s_tready drops once the queue and the execute stage together hold three.
// After HLT every further instruction returns the held PC with halted set.
// ----------------------------------------------------------------------------
module toy_register_machine_execute #(
    parameter int MEM_DEPTH  = 64,
    parameter int REG_COUNT  = 5,
    parameter int DATA_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // first_reg, second_reg, mem_addr, immediate, target_line, zero pad
    input  logic [tre_pkg::S_TDATA_W-1:0] s_tdata,
    // func, first_kind, second_kind
    input  logic [tre_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // next_pc, print_value, halted, zero pad
    output logic [tre_pkg::M_TDATA_W-1:0] m_tdata,
    // print_valid
    output logic [tre_pkg::M_TUSER_W-1:0] m_tuser
);

    tre_pkg::tre_instr_t  instr;
    tre_pkg::tre_result_t core_res;
    tre_pkg::tre_result_t head_res;
    logic                 core_res_valid;
    logic                 s1_busy;
    logic [1:0]           q_count;
    logic                 accept;

    assign instr.func        = tre_pkg::tre_func_t'(s_tuser[2:0]);
    assign instr.first_kind  = tre_pkg::tre_fkind_t'(s_tuser[3]);
    assign instr.second_kind = s_tuser[5:4];
    assign instr.first_reg   = s_tdata[2:0];
    assign instr.second_reg  = s_tdata[5:3];
    assign instr.mem_addr    = s_tdata[11:6];
    assign instr.immediate   = s_tdata[43:12];
    assign instr.target_line = s_tdata[59:44];

    assign s_tready = ({1'b0, q_count} + {2'b0, s1_busy}) < 3'(tre_pkg::OUTQ_DEPTH);
    assign accept   = s_tvalid && s_tready;

    tre_core #(
        .MEM_DEPTH  (MEM_DEPTH),
        .REG_COUNT  (REG_COUNT),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (accept),
        .in_instr  (instr),
        .s1_busy   (s1_busy),
        .res       (core_res),
        .res_valid (core_res_valid)
    );

    tre_outq u_outq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (core_res_valid),
        .push_res   (core_res),
        .pop_ready  (m_tready),
        .head_valid (m_tvalid),
        .head_res   (head_res),
        .count      (q_count)
    );

    assign m_tdata = {7'd0, head_res.halted, head_res.print_value, head_res.next_pc};
    assign m_tuser = head_res.print_valid;

endmodule

// ===== sv/tre_checker.sv =====
// ----------------------------------------------------------------------------
// Toy register machine execute - port checker
// Watches the result channel over time; bound to the top level.
// ----------------------------------------------------------------------------
`include "toy_register_machine_execute_defines.svh"

module tre_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [tre_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [tre_pkg::M_TUSER_W-1:0] m_tuser
);

    logic seen_halt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_halt_reg <= 1'b0;
        end else if (m_tvalid && m_tready && m_tdata[48]) begin
            seen_halt_reg <= 1'b1;
        end
    end

    `TRE_ASSERT_NEXT(a_hold_stalled, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    `TRE_ASSERT_IMPL(a_halt_sticky, aclk, aresetn, seen_halt_reg && m_tvalid, m_tdata[48])
    `TRE_ASSERT_IMPL(a_halt_no_print, aclk, aresetn, m_tvalid && m_tdata[48], !m_tuser[0] && m_tdata[47:16] == 32'd0)
    `TRE_ASSERT_RST(a_reset_idle, aclk, !aresetn, !m_tvalid)

endmodule

bind toy_register_machine_execute tre_checker u_tre_checker (.*);

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// Toy register machine execute - testbench
// Streams decoded instructions into the execute block and checks every
// result against a cycle-free model of the register file, data memory,
// program counter and halt flag kept inside the bench. Directed instructions
// cover the operand forms, wrap-around and out-of-range cases; random
// instructions follow, under random and back-to-back flow control, with one
// long result-side hold and a final halt.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_LEN   = 150;
    localparam int DRAIN_WAIT = 10;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [tre_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic [tre_pkg::S_TUSER_W-1:0] s_tuser  = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [tre_pkg::M_TDATA_W-1:0] m_tdata;
    logic [tre_pkg::M_TUSER_W-1:0] m_tuser;

    toy_register_machine_execute u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // machine state as the bench sees it
    logic [31:0] gpr  [5]  = '{default: '0};
    logic [31:0] dmem [64] = '{default: '0};
    logic [15:0] pc_q      = tre_pkg::PC_RESET;
    logic        halt_q    = 1'b0;

    tre_pkg::tre_instr_t  instr_q[$];
    tre_pkg::tre_result_t machine_results_q[$];
    tre_pkg::tre_instr_t  drv_instr;

    bit src_quiet  = 1'b0;
    bit snk_quiet  = 1'b0;
    int hold_reqs  = 0;
    int holds_done = 0;
    int send_gap   = 0;
    int snk_gap    = 0;
    int hold_left  = 0;

    int fails       = 0;
    int sent_count  = 0;
    int checked     = 0;
    int print_count = 0;
    int jump_count  = 0;

    function automatic logic [31:0] gpr_read(logic [2:0] idx);
        return (idx < 5) ? gpr[idx] : 32'd0;
    endfunction

    function automatic void gpr_write(logic [2:0] idx, logic [31:0] val);
        if (idx < 5)
            gpr[idx] = val;
    endfunction

    function automatic void queue_instr(tre_pkg::tre_instr_t ins);
        instr_q.insert(instr_q.size(), ins);
    endfunction

    function automatic tre_pkg::tre_result_t machine_execute(tre_pkg::tre_instr_t ins);
        tre_pkg::tre_result_t r;
        logic [31:0] opnd;
        logic [31:0] tested;
        logic [15:0] npc;
        r = '0;
        if (halt_q) begin
            r.next_pc = pc_q;
            r.halted  = 1'b1;
            return r;
        end
        npc = pc_q + 16'd1;
        case (ins.second_kind)
            tre_pkg::SK_REG:   opnd = gpr_read(ins.second_reg);
            tre_pkg::SK_MEM:   opnd = dmem[ins.mem_addr];
            tre_pkg::SK_CONST: opnd = ins.immediate;
            default:           opnd = '0;
        endcase
        tested = gpr_read(ins.first_reg);
        case (ins.func)
            tre_pkg::FUNC_MOV: begin
                if (ins.second_kind == tre_pkg::SK_CONST) begin
                    if (ins.first_kind == tre_pkg::FK_REG)
                        gpr_write(ins.first_reg, ins.immediate);
                    else
                        dmem[ins.mem_addr] = ins.immediate;
                end else if (ins.first_kind == tre_pkg::FK_REG &&
                             ins.second_kind == tre_pkg::SK_REG) begin
                    gpr_write(ins.second_reg, tested);
                end else if (ins.first_kind == tre_pkg::FK_REG &&
                             ins.second_kind == tre_pkg::SK_MEM) begin
                    dmem[ins.mem_addr] = tested;
                end else if (ins.first_kind == tre_pkg::FK_MEM &&
                             ins.second_kind == tre_pkg::SK_REG) begin
                    gpr_write(ins.second_reg, dmem[ins.mem_addr]);
                end
            end
            tre_pkg::FUNC_ADD: begin
                if (ins.second_kind != tre_pkg::SK_NONE)
                    gpr_write(ins.first_reg, tested + opnd);
            end
            tre_pkg::FUNC_SUB: begin
                if (ins.second_kind != tre_pkg::SK_NONE)
                    gpr_write(ins.first_reg, tested - opnd);
            end
            tre_pkg::FUNC_JMP: npc = ins.target_line;
            tre_pkg::FUNC_JPZ: begin
                if (tested == 32'd0)
                    npc = ins.target_line;
            end
            tre_pkg::FUNC_JPN: begin
                if (tested == 32'd0 || tested[31])
                    npc = ins.target_line;
            end
            tre_pkg::FUNC_PRN: begin
                r.print_valid = 1'b1;
                r.print_value = (ins.first_kind == tre_pkg::FK_REG) ? tested
                                                                    : dmem[ins.mem_addr];
                print_count++;
            end
            default: begin
                halt_q = 1'b1;
                npc    = pc_q;
            end
        endcase
        if (npc != pc_q + 16'd1 && ins.func != tre_pkg::FUNC_HLT)
            jump_count++;
        pc_q      = npc;
        r.next_pc = pc_q;
        r.halted  = halt_q;
        return r;
    endfunction

    function automatic tre_pkg::tre_instr_t make_instr(tre_pkg::tre_func_t f,
                                                       tre_pkg::tre_fkind_t fk,
                                                       logic [1:0] sk,
                                                       logic [2:0] r1, logic [2:0] r2,
                                                       logic [5:0] addr, logic [31:0] imm,
                                                       logic [15:0] target);
        tre_pkg::tre_instr_t ins;
        ins.func        = f;
        ins.first_kind  = fk;
        ins.second_kind = sk;
        ins.first_reg   = r1;
        ins.second_reg  = r2;
        ins.mem_addr    = addr;
        ins.immediate   = imm;
        ins.target_line = target;
        return ins;
    endfunction

    function automatic tre_pkg::tre_instr_t random_instr();
        tre_pkg::tre_instr_t ins;
        ins.func        = tre_pkg::tre_func_t'($urandom_range(0, 6));
        ins.first_kind  = tre_pkg::tre_fkind_t'($urandom_range(0, 1));
        ins.second_kind = ($urandom_range(0, 15) == 0) ? tre_pkg::SK_NONE
                                                       : 2'($urandom_range(0, 2));
        ins.first_reg   = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                                      : 3'($urandom_range(0, 4));
        ins.second_reg  = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                                      : 3'($urandom_range(0, 4));
        ins.mem_addr    = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 7));
        case ($urandom_range(0, 3))
            0: ins.immediate = $urandom;
            1: ins.immediate = 32'($urandom_range(0, 16)) - 32'd8;
            2: begin
                case ($urandom_range(0, 3))
                    0: ins.immediate = 32'h8000_0000;
                    1: ins.immediate = 32'h7FFF_FFFF;
                    2: ins.immediate = 32'hFFFF_FFFF;
                    default: ins.immediate = 32'h0000_0001;
                endcase
            end
            default: ins.immediate = '0;
        endcase
        ins.target_line = 16'($urandom);
        return ins;
    endfunction

    task automatic wait_drained();
        while (instr_q.size() != 0 || s_tvalid || machine_results_q.size() != 0)
            @(negedge aclk);
    endtask

    always @(posedge aclk) begin : instr_driver
        logic fire;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else begin
            fire = s_tvalid && s_tready;
            if (fire) begin
                machine_results_q.insert(machine_results_q.size(),
                                         machine_execute(drv_instr));
                sent_count++;
            end
            if (!s_tvalid || fire) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (instr_q.size() != 0) begin
                    drv_instr <= instr_q[0];
                    s_tdata   <= {4'b0, instr_q[0].target_line, instr_q[0].immediate,
                                  instr_q[0].mem_addr, instr_q[0].second_reg,
                                  instr_q[0].first_reg};
                    s_tuser   <= {instr_q[0].second_kind, instr_q[0].first_kind,
                                  instr_q[0].func};
                    s_tvalid  <= 1'b1;
                    send_gap  <= src_quiet ? 0 : $urandom_range(0, 19);
                    void'(instr_q.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // count down the long result-side hold
    always @(posedge aclk) begin : sink_hold
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_reqs != holds_done) begin
            hold_left  <= HOLD_LEN;
            holds_done <= hold_reqs;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge aclk) begin : result_monitor
        tre_pkg::tre_result_t want;
        int                   gap_n;
        if (!aresetn) begin
            m_tready <= 1'b0;
            snk_gap  <= 0;
        end else begin
            gap_n = snk_gap;
            if (m_tvalid && m_tready) begin
                if (machine_results_q.size() == 0) begin
                    $error("unexpected result transfer: m_tdata %h m_tuser %h", m_tdata, m_tuser);
                    fails++;
                end else begin
                    want = machine_results_q.pop_front();
                    if (m_tdata[15:0] !== want.next_pc) begin
                        $error("next_pc: expected %0d, got %0d", want.next_pc, m_tdata[15:0]);
                        fails++;
                    end
                    if (m_tuser[0] !== want.print_valid) begin
                        $error("print_valid: expected %0d, got %0d", want.print_valid, m_tuser[0]);
                        fails++;
                    end
                    if (m_tdata[47:16] !== want.print_value) begin
                        $error("print_value: expected %h, got %h", want.print_value,
                               m_tdata[47:16]);
                        fails++;
                    end
                    if (m_tdata[48] !== want.halted) begin
                        $error("halted: expected %0d, got %0d", want.halted, m_tdata[48]);
                        fails++;
                    end
                    checked++;
                end
                gap_n = snk_quiet ? 0 : $urandom_range(0, 19);
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
            end else if (gap_n > 0) begin
                gap_n--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
            snk_gap <= gap_n;
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // operand forms, wrap-around and out-of-range indexes
        queue_instr(make_instr(tre_pkg::FUNC_MOV, tre_pkg::FK_REG, tre_pkg::SK_CONST,
                               3'd0, 3'd0, 6'd0, 32'h7FFF_FFFF, 16'h0));
        queue_instr(make_instr(tre_pkg::FUNC_MOV, tre_pkg::FK_REG, tre_pkg::SK_CONST,
                               3'd1, 3'd0, 6'd0, 32'h8000_0000, 16'h0));
        queue_instr(make_instr(tre_pkg::FUNC_MOV, tre_pkg::FK_MEM, tre_pkg::SK_CONST,
                               3'd0, 3'd0, 6'd63, 32'hFFFF_FFFF, 16'h0));
        queue_instr(make_instr(tre_pkg::FUNC_MOV, tre_pkg::FK_REG, tre_pkg::SK_REG,
                               3'd0, 3'd2, 6'd0, 32'h0, 16'h0));
        queue_instr(make_instr(tre_pkg::FUNC_MOV, tre_pkg::FK_REG, tre_pkg::SK_MEM,
                               3'd1, 3'd0, 6'd0, 32'h0, 16'h0));
        queue_instr(make_instr(tre_pkg::FUNC_MOV, tre_pkg::FK_MEM, tre_pkg::SK_REG,
                               3'd0, 3'd3, 6'd63, 32'h0, 16'h0));
        queue_instr(make_instr(tre_pkg::FUNC_MOV, tre_pkg::FK_MEM, tre_pkg::SK_MEM,
                               3'd0, 3'd0, 6'd63, 32'h0, 16'h0));
        queue_instr(make_instr(tre_pkg::FUNC_MOV, tre_pkg::FK_REG, tre_pkg::SK_NONE,
                               3'd4, 3'd4, 6'd5, 32'h5, 16'h0));
        queue_instr(make_instr(tre_pkg::FUNC_ADD, tre_pkg::FK_REG, tre_pkg::SK_CONST,
                               3'd0, 3'd0, 6'd0, 32'h1, 16'h0));
        queue_instr(make_instr(tre_pkg::FUNC_ADD, tre_pkg::FK_MEM, tre_pkg::SK_MEM,
                               3'd3, 3'd0, 6'd63, 32'h0, 16'h0));
        queue_instr(make_instr(tre_pkg::FUNC_SUB, tre_pkg::FK_REG, tre_pkg::SK_REG,
                               3'd4, 3'd1, 6'd0, 32'h0, 16'h0));
        queue_instr(make_instr(tre_pkg::FUNC_SUB, tre_pkg::FK_REG, tre_pkg::SK_NONE,
                               3'd2, 3'd0, 6'd0, 32'h9, 16'h0));
        queue_instr(make_instr(tre_pkg::FUNC_ADD, tre_pkg::FK_REG, tre_pkg::SK_CONST,
                               3'd7, 3'd0, 6'd0, 32'h3, 16'h0));
        queue_instr(make_instr(tre_pkg::FUNC_MOV, tre_pkg::FK_REG, tre_pkg::SK_CONST,
                               3'd5, 3'd0, 6'd0, 32'h4, 16'h0));
        queue_instr(make_instr(tre_pkg::FUNC_PRN, tre_pkg::FK_REG, tre_pkg::SK_REG,
                               3'd5, 3'd0, 6'd0, 32'h0, 16'h0));
        queue_instr(make_instr(tre_pkg::FUNC_ADD, tre_pkg::FK_REG, tre_pkg::SK_REG,
                               3'd2, 3'd7, 6'd0, 32'h0, 16'h0));
        queue_instr(make_instr(tre_pkg::FUNC_PRN, tre_pkg::FK_MEM, tre_pkg::SK_REG,
                               3'd0, 3'd0, 6'd63, 32'h0, 16'h0));
        queue_instr(make_instr(tre_pkg::FUNC_PRN, tre_pkg::FK_REG, tre_pkg::SK_REG,
                               3'd1, 3'd0, 6'd0, 32'h0, 16'h0));
        queue_instr(make_instr(tre_pkg::FUNC_JMP, tre_pkg::FK_REG, tre_pkg::SK_REG,
                               3'd0, 3'd0, 6'd0, 32'h0, 16'hFFFF));
        queue_instr(make_instr(tre_pkg::FUNC_PRN, tre_pkg::FK_MEM, tre_pkg::SK_REG,
                               3'd0, 3'd0, 6'd0, 32'h0, 16'h0));
        queue_instr(make_instr(tre_pkg::FUNC_JPZ, tre_pkg::FK_REG, tre_pkg::SK_REG,
                               3'd4, 3'd0, 6'd0, 32'h0, 16'h1234));
        queue_instr(make_instr(tre_pkg::FUNC_JPN, tre_pkg::FK_REG, tre_pkg::SK_REG,
                               3'd4, 3'd0, 6'd0, 32'h0, 16'h4321));
        queue_instr(make_instr(tre_pkg::FUNC_JPZ, tre_pkg::FK_MEM, tre_pkg::SK_REG,
                               3'd6, 3'd0, 6'd0, 32'h0, 16'h0));
        queue_instr(make_instr(tre_pkg::FUNC_JPN, tre_pkg::FK_MEM, tre_pkg::SK_REG,
                               3'd2, 3'd0, 6'd0, 32'h0, 16'hAAAA));
        queue_instr(make_instr(tre_pkg::FUNC_JPN, tre_pkg::FK_REG, tre_pkg::SK_REG,
                               3'd7, 3'd0, 6'd0, 32'h0, 16'h5555));
        wait_drained();

        repeat (300) queue_instr(random_instr());
        wait_drained();

        // back-to-back sends against a stalled result side
        src_quiet = 1'b1;
        hold_reqs++;
        repeat (40) queue_instr(random_instr());
        wait_drained();

        snk_quiet = 1'b1;
        repeat (250) queue_instr(random_instr());
        wait_drained();

        src_quiet = 1'b0;
        snk_quiet = 1'b0;
        repeat (300) queue_instr(random_instr());
        wait_drained();

        // halt, then confirm everything after it is ignored
        queue_instr(make_instr(tre_pkg::FUNC_HLT, tre_pkg::FK_MEM, tre_pkg::SK_NONE,
                               3'd7, 3'd7, 6'd63, 32'hFFFF_FFFF, 16'hFFFF));
        queue_instr(make_instr(tre_pkg::FUNC_PRN, tre_pkg::FK_REG, tre_pkg::SK_REG,
                               3'd0, 3'd0, 6'd0, 32'h0, 16'h0));
        queue_instr(make_instr(tre_pkg::FUNC_MOV, tre_pkg::FK_REG, tre_pkg::SK_CONST,
                               3'd1, 3'd0, 6'd0, 32'h7, 16'h0));
        queue_instr(make_instr(tre_pkg::FUNC_JMP, tre_pkg::FK_REG, tre_pkg::SK_REG,
                               3'd0, 3'd0, 6'd0, 32'h0, 16'h0042));
        queue_instr(make_instr(tre_pkg::FUNC_HLT, tre_pkg::FK_REG, tre_pkg::SK_REG,
                               3'd0, 3'd0, 6'd0, 32'h0, 16'h0));
        repeat (20) queue_instr(random_instr());
        wait_drained();
        repeat (DRAIN_WAIT) @(negedge aclk);

        $display("Ran %0d instructions, %0d results compared, including %0d prints and",
                 sent_count, checked, print_count);
        $display("%0d taken jumps, one long result stall and a final halt.", jump_count);
        if (fails == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #1_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/tre_pkg.sv
sv/tre_ram.sv
sv/tre_core.sv
sv/tre_outq.sv
sv/toy_register_machine_execute.sv
sv/tre_checker.sv
bench/tb_top.sv
